// ===== hw/rtl/npc_pkg.sv =====
// Shared types and constants of the nearest palette color search block.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  // Fixed field widths.
  localparam int COMP_W = 8;
  localparam int IDX_W  = 8;
  localparam int DIST_W = 18;
  localparam int SQ_W   = 16;
  localparam int PENS_W = 9;

  // Pen count after reset.
  localparam logic [PENS_W-1:0] PENS_RESET = 9'd16;

  // Input item kinds carried in tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  // Tag that travels alongside one palette entry through the distance unit.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/npc_dist_unit.sv =====
// Shared squared RGB distance unit with a tag pipeline.
`timescale 1ns / 1ps
`default_nettype none

module npc_dist_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire npc_pkg::tag_t                in_tag,
  input  wire npc_pkg::rgb_t                entry,
  input  wire npc_pkg::rgb_t                target,
  output npc_pkg::tag_t                     out_tag,
  output logic [npc_pkg::DIST_W-1:0]        sq_sum
);

  logic [npc_pkg::COMP_W-1:0] dr, dg, db;
  logic [npc_pkg::SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  npc_pkg::tag_t              tag_r;

  // Absolute component differences.
  assign dr = (entry.red   > target.red)   ? entry.red   - target.red
                                           : target.red   - entry.red;
  assign dg = (entry.green > target.green) ? entry.green - target.green
                                           : target.green - entry.green;
  assign db = (entry.blue  > target.blue)  ? entry.blue  - target.blue
                                           : target.blue  - entry.blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= in_tag;
    end
    sq_r_r <= npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
    sq_g_r <= npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
    sq_b_r <= npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);
  end

  assign out_tag = tag_r;
  assign sq_sum  = npc_pkg::DIST_W'(sq_r_r) + npc_pkg::DIST_W'(sq_g_r)
                 + npc_pkg::DIST_W'(sq_b_r);

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_palette_color_search_core.sv =====
// Top level of the nearest palette color search block.
// A write item stores one palette entry; no result follows.
// A match item scans N entries, one per cycle (N = pens in use, clamped to
// 1..MAX_ENTRIES); its result is shown once the output register is free, and
// the next item can be taken in the same cycle that the result is shown.
// Synchronous active-low reset clears the sequencer and the output valid and
// sets pens in use to 16; the palette is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_search_core #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // entry_index [7:0], red [15:8], green [23:16], blue [31:24]
  input  wire logic [31:0] in_tdata,
  // command [0]: write entry or match target
  input  wire logic        in_tuser,
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // best_index [7:0], match_distance [25:8], zero [31:26]
  output logic [31:0]      out_tdata,
  // Pens in use register.
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [npc_pkg::PENS_W-1:0] MAX_CNT = npc_pkg::PENS_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // Unpacked input fields.
  logic [npc_pkg::IDX_W-1:0] in_idx;
  npc_pkg::rgb_t             in_rgb;
  logic                      in_acc;

  assign in_idx       = in_tdata[7:0];
  assign in_rgb.red   = in_tdata[15:8];
  assign in_rgb.green = in_tdata[23:16];
  assign in_rgb.blue  = in_tdata[31:24];
  assign in_acc       = in_tvalid && in_tready;

  // Palette memory, one write and one registered read per cycle.
  npc_pkg::rgb_t mem [MAX_ENTRIES];
  npc_pkg::rgb_t mem_q_r;

  // Control and payload registers.
  state_t                      state_r, state_nxt;
  logic [npc_pkg::PENS_W-1:0]  pens_r, pens_nxt;
  logic [npc_pkg::PENS_W-1:0]  cnt_m1_r, cnt_m1_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  npc_pkg::tag_t               tag1_r, tag1_nxt;
  npc_pkg::rgb_t               tgt_r, tgt_nxt;
  logic [npc_pkg::DIST_W-1:0]  best_d_r, best_d_nxt;
  logic [npc_pkg::IDX_W-1:0]   best_i_r, best_i_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_data_r, out_data_nxt;

  npc_pkg::tag_t               du_tag;
  logic [npc_pkg::DIST_W-1:0]  du_dist;
  logic                        take;
  logic                        wr_ok;

  // The distance unit works on the entry read in the previous cycle.
  npc_dist_unit u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (tag1_r),
    .entry   (mem_q_r),
    .target  (tgt_r),
    .out_tag (du_tag),
    .sq_sum  (du_dist)
  );

  // The first entry always wins; later ones only on a strictly smaller distance.
  assign take  = du_tag.valid && ((du_tag.idx == '0) || (du_dist < best_d_r));
  assign wr_ok = in_acc && (in_tuser == npc_pkg::CMD_WRITE)
              && (npc_pkg::PENS_W'(in_idx) < MAX_CNT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_idx[AW-1:0]] <= in_rgb;
    end
    mem_q_r <= mem[rd_idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    pens_nxt      = pens_r;
    cnt_m1_nxt    = cnt_m1_r;
    rd_idx_nxt    = rd_idx_r;
    tag1_nxt      = '0;
    tgt_nxt       = tgt_r;
    best_d_nxt    = best_d_r;
    best_i_nxt    = best_i_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      pens_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (take) begin
      best_d_nxt = du_dist;
      best_i_nxt = du_tag.idx;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == npc_pkg::CMD_MATCH)) begin
          tgt_nxt    = in_rgb;
          rd_idx_nxt = '0;
          // Zero pens search one entry; too many pens saturate at the store size.
          if (pens_r == '0) begin
            cnt_m1_nxt = '0;
          end else if (pens_r > MAX_CNT) begin
            cnt_m1_nxt = MAX_CNT - 1'b1;
          end else begin
            cnt_m1_nxt = pens_r - 1'b1;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tag1_nxt.valid = 1'b1;
        tag1_nxt.idx   = npc_pkg::IDX_W'(rd_idx_r);
        tag1_nxt.last  = (npc_pkg::PENS_W'(rd_idx_r) == cnt_m1_r);
        rd_idx_nxt     = rd_idx_r + 1'b1;
        if (tag1_nxt.last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (du_tag.valid && du_tag.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, best_d_r, best_i_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pens_r      <= npc_pkg::PENS_RESET;
      tag1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pens_r      <= pens_nxt;
      tag1_r      <= tag1_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_m1_r   <= cnt_m1_nxt;
    rd_idx_r   <= rd_idx_nxt;
    tgt_r      <= tgt_nxt;
    best_d_r   <= best_d_nxt;
    best_i_r   <= best_i_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/npc_checker.sv =====
// Port-level assertions for the nearest palette color search block, with bind.
`timescale 1ns / 1ps
`default_nettype none

module npc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // The distance never exceeds the largest squared RGB distance.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] <= 18'd195075))
    else $error("best distance out of range");

  // A match item starts a scan, so no item is taken in the next cycle.
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == npc_pkg::CMD_MATCH) |=> !in_tready)
    else $error("item taken during a scan");

  // A write item leaves the block ready for the next item.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == npc_pkg::CMD_WRITE) |=> in_tready)
    else $error("block busy after a write item");

endmodule

bind nearest_palette_color_search_core npc_checker u_npc_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the nearest palette color search core.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_PENS    = 256;
  localparam int DRAIN_LIMIT = 100000;
  // Wait after the last drain, long enough to cover the longest search of MAX_PENS entries.
  localparam int TAIL_CYCLES = 300;

  // One predicted search answer, in the order the block returns them.
  typedef struct packed {
    logic [npc_pkg::DIST_W-1:0] sq_dist;
    logic [npc_pkg::IDX_W-1:0]  idx;
  } closest_t;

  // The scoreboard keeps its own palette and pen count. For every search it
  // predicts the winner, and it checks each result word against the oldest one.
  class palette_scoreboard;
    npc_pkg::rgb_t              palette [MAX_PENS];
    logic [npc_pkg::PENS_W-1:0] pens;
    closest_t                   expected_closest [$];
    int                         errors;
    int                         writes;
    int                         searches;
    int                         checked;

    function new();
      pens     = npc_pkg::PENS_RESET;
      errors   = 0;
      writes   = 0;
      searches = 0;
      checked  = 0;
    endfunction

    // A pen count of zero searches entry 0 only. Counts above the store size saturate.
    static function int unsigned pens_to_count(logic [npc_pkg::PENS_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_PENS) return MAX_PENS;
      return 32'(value);
    endfunction

    function void set_pens(logic [npc_pkg::PENS_W-1:0] value);
      pens = value;
    endfunction

    // Squared Euclidean scan with a strict less-than, so the lowest index wins a tie.
    function closest_t find_closest(npc_pkg::rgb_t target);
      closest_t    best;
      int unsigned count;
      int unsigned sq_sum;
      int unsigned best_sq;
      int          dr;
      int          dg;
      int          db;
      count   = pens_to_count(pens);
      best_sq = 32'hFFFF_FFFF;
      best.idx = '0;
      for (int unsigned i = 0; i < count; i++) begin
        dr     = int'(target.red)   - int'(palette[i].red);
        dg     = int'(target.green) - int'(palette[i].green);
        db     = int'(target.blue)  - int'(palette[i].blue);
        sq_sum = unsigned'(dr * dr + dg * dg + db * db);
        if (sq_sum < best_sq) begin
          best_sq  = sq_sum;
          best.idx = npc_pkg::IDX_W'(i);
        end
      end
      best.sq_dist = npc_pkg::DIST_W'(best_sq);
      return best;
    endfunction

    function void note_input(logic cmd, logic [npc_pkg::IDX_W-1:0] idx,
                             npc_pkg::rgb_t color);
      if (cmd == npc_pkg::CMD_WRITE) begin
        palette[idx] = color;
        writes++;
      end else begin
        expected_closest.push_back(find_closest(color));
        searches++;
      end
    endfunction

    function void check_result(logic [31:0] word);
      closest_t want;
      if (expected_closest.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = expected_closest.pop_front();
      checked++;
      if (word[7:0] !== want.idx) begin
        $display("%0t: best_index mismatch, expected %0d, actual %0d",
                 $time, want.idx, word[7:0]);
        errors++;
      end
      if (word[25:8] !== want.sq_dist) begin
        $display("%0t: match distance mismatch, expected %0d, actual %0d",
                 $time, want.sq_dist, word[25:8]);
        errors++;
      end
      if (word[31:26] !== 6'b0) begin
        $display("%0t: padding bits mismatch, expected 0, actual %b",
                 $time, word[31:26]);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_tvalid   = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata    = '0;
  logic                       in_tuser    = npc_pkg::CMD_WRITE;
  logic                       out_tvalid;
  logic                       out_tready  = 1'b0;
  logic [31:0]                out_tdata;
  logic                       cfg_wr_en   = 1'b0;
  logic [npc_pkg::PENS_W-1:0] cfg_wr_data = '0;

  palette_scoreboard sb;
  // While calm is set, neither side inserts idle cycles.
  bit                calm;
  // Entries written since reset. A search must never reach an entry that was not written.
  bit                written [MAX_PENS];
  int                items_sent;
  int                pen_settings;
  int unsigned       min_count;
  int unsigned       max_count;

  nearest_palette_color_search_core #(
    .MAX_ENTRIES(MAX_PENS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs. This is far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Colors that favor the edges of the range and repeated shades, so that ties
  // and the largest distances come up often.
  function automatic npc_pkg::rgb_t random_color();
    npc_pkg::rgb_t c;
    case ($urandom_range(0, 3))
      0: begin
        c.red   = 8'($urandom_range(0, 1) * 255);
        c.green = 8'($urandom_range(0, 1) * 255);
        c.blue  = 8'($urandom_range(0, 1) * 255);
      end
      1: begin
        c.red   = 8'($urandom_range(0, 3) * 64);
        c.green = 8'($urandom_range(0, 3) * 64);
        c.blue  = 8'($urandom_range(0, 3) * 64);
      end
      default: c = 24'($urandom);
    endcase
    return c;
  endfunction

  // Presents one item after a random gap and returns at the edge where it is accepted.
  // tvalid stays high on return. Any caller that lets time pass before the next item
  // goes through wait_drained, which lowers it.
  task automatic send_item(logic cmd, logic [npc_pkg::IDX_W-1:0] idx,
                           npc_pkg::rgb_t color);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {color.blue, color.green, color.red, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, idx, color);
    if (cmd == npc_pkg::CMD_WRITE) written[idx] = 1'b1;
    items_sent++;
  endtask

  // Holds the sender off until every search has answered. It then waits on so that
  // a trailing palette write settles before the pen count may change.
  task automatic wait_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (sb.expected_closest.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Writes the pen count register. The block must be idle when this is called.
  task automatic write_pens(logic [npc_pkg::PENS_W-1:0] value);
    int unsigned count;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_pens(value);
    count = palette_scoreboard::pens_to_count(value);
    pen_settings++;
    if (count < min_count) min_count = count;
    if (count > max_count) max_count = count;
    @(posedge clk);
  endtask

  // Writes every entry below count that has not been written yet, so that a search
  // never reads undefined contents.
  task automatic fill_palette(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (!written[i]) send_item(npc_pkg::CMD_WRITE, npc_pkg::IDX_W'(i), random_color());
    end
  endtask

  // The result side stalls for a random number of cycles before each result. The
  // scoreboard checks every result word it accepts.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  initial begin : stimulus
    npc_pkg::rgb_t              seed_colors [8];
    npc_pkg::rgb_t              color;
    logic [npc_pkg::PENS_W-1:0] pens;
    int unsigned                count;
    int                         phase_items;

    sb           = new();
    calm         = 1'b0;
    items_sent   = 0;
    pen_settings = 0;
    min_count    = 32'(npc_pkg::PENS_RESET);
    max_count    = 32'(npc_pkg::PENS_RESET);
    seed_colors  = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                     24'h0000FF, 24'hFF0000, 24'hAA55AA, 24'h55AA55};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run at the pen count left by reset (16). Black, white and the
    // primaries come first. Entry 5 repeats entry 2 to set up a tie. The upper
    // entries get spread colors.
    for (int i = 0; i < 16; i++) begin
      if (i < 8) color = seed_colors[i];
      else color = {8'(i * 29), 8'(255 - i * 13), 8'(i * 7)};
      send_item(npc_pkg::CMD_WRITE, npc_pkg::IDX_W'(i), color);
    end
    // Exact hits on white and black, a red target that ties entries 2 and 5, a
    // mid gray, and the alternating-bit entry. A search ignores the index field,
    // so it carries junk here.
    send_item(npc_pkg::CMD_MATCH, 8'hFF, 24'hFFFFFF);
    send_item(npc_pkg::CMD_MATCH, 8'h00, 24'h000000);
    send_item(npc_pkg::CMD_MATCH, 8'h5A, 24'hFF0000);
    send_item(npc_pkg::CMD_MATCH, 8'hA5, 24'h808080);
    send_item(npc_pkg::CMD_MATCH, 8'($urandom), 24'hAA55AA);
    wait_drained();
    // A pen count of zero searches only the black entry 0, and a white target
    // then gives the largest possible distance.
    write_pens('0);
    send_item(npc_pkg::CMD_MATCH, 8'($urandom), 24'hFFFFFF);
    wait_drained();
    write_pens(9'd1);
    send_item(npc_pkg::CMD_MATCH, 8'($urandom), 24'h7F7F7F);
    wait_drained();

    // Random part. Each phase drains, picks a pen count, fills any entries the new
    // count would expose, and then mixes palette writes with searches. Most phases
    // are short scans. Full and saturated counts run only a few searches each.
    while (items_sent < 450) begin
      wait_drained();
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       pens = '0;
        1:       pens = 9'd1;
        2:       pens = 9'd256;
        3:       pens = 9'($urandom_range(257, 511));
        4:       pens = 9'($urandom_range(2, 256));
        default: pens = 9'($urandom_range(2, 24));
      endcase
      write_pens(pens);
      count = palette_scoreboard::pens_to_count(pens);
      fill_palette(count);
      phase_items = (count > 64) ? $urandom_range(4, 8) : $urandom_range(15, 40);
      repeat (phase_items) begin
        // Now and then the sender holds off until every search has answered.
        if ($urandom_range(0, 14) == 0) wait_drained();
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(npc_pkg::CMD_WRITE, 8'($urandom), random_color());
          end else begin
            send_item(npc_pkg::CMD_WRITE, npc_pkg::IDX_W'($urandom_range(0, count - 1)),
                      random_color());
          end
        end else begin
          // A quarter of the targets copy a searched entry, which forces a zero
          // distance and often a tie against an earlier duplicate.
          if ($urandom_range(0, 3) == 0) color = sb.palette[$urandom_range(0, count - 1)];
          else color = random_color();
          send_item(npc_pkg::CMD_MATCH, 8'($urandom), color);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_closest.size() != 0) begin
      $display("%0t: %0d search results never arrived", $time,
               sb.expected_closest.size());
      sb.errors += sb.expected_closest.size();
    end

    $display("Run covered %0d palette writes and %0d searches, %0d results checked.",
             sb.writes, sb.searches, sb.checked);
    $display("Pen count was set %0d times, searches spanned %0d to %0d entries.",
             pen_settings, min_count, max_count);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/npc_pkg.sv
hw/rtl/npc_dist_unit.sv
hw/rtl/nearest_palette_color_search_core.sv
hw/rtl/npc_checker.sv
dv/testbench.sv
